### sv/sapq_pkg.sv
// Shared types and constants for the sorted-array priority queue.
`default_nettype none

package sapq_pkg;

    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 5;

    // Operation codes carried on the input tuser
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_DELETE = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    // Output word: status, count, head value, padded to whole bytes
    localparam int RES_BITS = STATUS_W + COUNT_W + VALUE_W;
    localparam int RES_W    = ((RES_BITS + 7) / 8) * 8;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic capture;   // latch operation and value of the accepted word
        logic compare;   // compare value against every held slot
        logic commit;    // update slots and load the result register
    } sapq_cmd_t;

endpackage

`default_nettype wire

### sv/sorted_array_priority_queue.sv
// Top level of the sorted-array priority queue of signed 32-bit values.
// The word is captured at its accepting edge; the controller then compares it and
// updates the slots, and the result becomes valid when the update commits.
// No new word is accepted until the controller's three-step sequence returns to idle.
// The update may wait in its last step while the previous result is not taken.
// Reset (rst_n low, asynchronous) empties the queue and drops any pending result.
`default_nettype none

module sorted_array_priority_queue #(
    parameter int DEPTH = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         s_tvalid,
    output logic                        s_tready,
    input  wire  [sapq_pkg::VALUE_W-1:0] s_tdata,  // value[31:0]
    input  wire                         s_tuser,  // operation[0]
    output logic                        m_tvalid,
    input  wire                         m_tready,
    output logic [sapq_pkg::RES_W-1:0]  m_tdata   // status[1:0], count[6:2], head_value[38:7]
);
    import sapq_pkg::*;

    sapq_cmd_t           cmd;
    logic [STATUS_W-1:0] res_status;
    logic [COUNT_W-1:0]  res_count;
    logic [VALUE_W-1:0]  res_head;

    sapq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cmd       (cmd)
    );

    sapq_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .in_op      (s_tuser),
        .in_value   (s_tdata),
        .res_status (res_status),
        .res_count  (res_count),
        .res_head   (res_head)
    );

    // Pack the result word, padding to whole bytes
    assign m_tdata = RES_W'({res_head, res_count, res_status});

    // One word in flight: no accept right after an accept
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while a word is in flight");

    // Empty status only with an empty queue
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == ST_EMPTY)) |-> (m_tdata[6:2] == '0))
        else $error("empty status with nonzero count");

    // Overflow status only with a full queue
    a_overflow_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == ST_OVERFLOW)) |-> (m_tdata[6:2] == COUNT_W'(DEPTH)))
        else $error("overflow status with queue not full");

    // A waiting result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("pending result changed before it was taken");

endmodule

`default_nettype wire

### sv/sapq_ctrl.sv
// Controller state machine for the sorted-array priority queue.
`default_nettype none

module sapq_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    output sapq_pkg::sapq_cmd_t  cmd
);
    import sapq_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_UPD
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    // Result slot is free when empty or being drained this cycle
    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    // Decode commands and next state
    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_CMP;
                end
            end
            S_CMP:
            begin
                cmd.compare = 1'b1;
                state_next  = S_UPD;
            end
            S_UPD:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

### sv/sapq_dp.sv
// Datapath of the sorted-array priority queue: slot array, compares, result.
`default_nettype none

module sapq_dp #(
    parameter int DEPTH = 16
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  sapq_pkg::sapq_cmd_t               cmd,
    input  wire                               in_op,
    input  wire  [sapq_pkg::VALUE_W-1:0]      in_value,
    output logic [sapq_pkg::STATUS_W-1:0]     res_status,
    output logic [sapq_pkg::COUNT_W-1:0]      res_count,
    output logic [sapq_pkg::VALUE_W-1:0]      res_head
);
    import sapq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    logic signed [VALUE_W-1:0] slot_reg [DEPTH];
    logic signed [VALUE_W-1:0] slot_next [DEPTH];
    logic [CW-1:0]             count_reg;
    logic [CW-1:0]             count_next;
    logic                      op_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [DEPTH-1:0]          ge_reg;   // value >= slot, held slots only
    logic [DEPTH-1:0]          le_reg;   // slot <= value, held slots only
    logic [DEPTH-1:0]          eq_reg;   // slot == value, held slots only
    logic [DEPTH-1:0]          tail;     // insert position and later
    logic                      full;
    logic                      empty;
    logic                      found;
    logic                      do_ins;
    logic                      do_del;
    logic [STATUS_W-1:0]       status;

    assign full   = (count_reg == CW'(DEPTH));
    assign empty  = (count_reg == '0);
    assign found  = |eq_reg;
    assign do_ins = (op_reg == OP_INSERT) && !full;
    assign do_del = (op_reg == OP_DELETE) && found;

    // Per-slot shift select
    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_slot
            assign tail[i] = ge_reg[i] || (count_reg == CW'(i));

            if (i == 0)
            begin : g_first
                always_comb
                begin
                    slot_next[i] = slot_reg[i];
                    if (do_ins && tail[i])
                        slot_next[i] = value_reg;
                    else if (do_del && le_reg[i] && (DEPTH > 1))
                        slot_next[i] = slot_reg[(DEPTH > 1) ? 1 : 0];
                end
            end
            else if (i == DEPTH - 1)
            begin : g_last
                always_comb
                begin
                    slot_next[i] = slot_reg[i];
                    if (do_ins && tail[i])
                        slot_next[i] = tail[i-1] ? slot_reg[i-1] : value_reg;
                end
            end
            else
            begin : g_mid
                always_comb
                begin
                    slot_next[i] = slot_reg[i];
                    if (do_ins && tail[i])
                        slot_next[i] = tail[i-1] ? slot_reg[i-1] : value_reg;
                    else if (do_del && le_reg[i])
                        slot_next[i] = slot_reg[i+1];
                end
            end
        end
    endgenerate

    // Pick the status and the new fill count
    always_comb
    begin
        count_next = count_reg;
        if (op_reg == OP_INSERT)
        begin
            if (full)
                status = ST_OVERFLOW;
            else
            begin
                status     = ST_DONE;
                count_next = count_reg + 1'b1;
            end
        end
        else if (empty)
            status = ST_EMPTY;
        else if (!found)
            status = ST_NOTFOUND;
        else
        begin
            status     = ST_DONE;
            count_next = count_reg - 1'b1;
        end
    end

    // Fill count is control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            count_reg <= '0;
        else if (cmd.commit)
            count_reg <= count_next;
    end

    // Capture, compare and update the slots; load the result word
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= in_op;
            value_reg <= $signed(in_value);
        end
        if (cmd.compare)
        begin
            for (int k = 0; k < DEPTH; k++)
            begin
                ge_reg[k] <= (count_reg > CW'(k)) && (value_reg >= slot_reg[k]);
                le_reg[k] <= (count_reg > CW'(k)) && (slot_reg[k] <= value_reg);
                eq_reg[k] <= (count_reg > CW'(k)) && (slot_reg[k] == value_reg);
            end
        end
        if (cmd.commit)
        begin
            for (int k = 0; k < DEPTH; k++)
                slot_reg[k] <= slot_next[k];
            res_status <= status;
            res_count  <= COUNT_W'(count_next);
            res_head   <= (count_next == '0) ? '0 : slot_next[0];
        end
    end

endmodule

`default_nettype wire

### tb/sv/sapq_checker.sv
// Checker for the priority queue: shadow queue, expected results and comparison.
`timescale 1ns / 1ps

module sapq_checker #(
    parameter int DEPTH = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [sapq_pkg::VALUE_W-1:0] s_tdata,   // value[31:0]
    input  logic                         s_tuser,   // operation[0]
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic [sapq_pkg::RES_W-1:0]   m_tdata,   // status[1:0], count[6:2], head_value[38:7]
    output int                           fail_count,
    output int                           outstanding,
    output int                           results_seen,
    output int                           overflow_seen,
    output int                           empty_seen,
    output int                           notfound_seen,
    output int                           peak_fill
);
    import sapq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [COUNT_W-1:0]        count;
        logic signed [VALUE_W-1:0] head;
    } queue_result_t;

    // Shadow copy of the queue, largest value in slot 0
    logic signed [VALUE_W-1:0] shadow_slots [DEPTH];
    int                        shadow_fill;

    queue_result_t expected_results [$];
    queue_result_t predicted;
    queue_result_t observed;
    queue_result_t oldest;

    initial
    begin
        fail_count    = 0;
        outstanding   = 0;
        results_seen  = 0;
        overflow_seen = 0;
        empty_seen    = 0;
        notfound_seen = 0;
        peak_fill     = 0;
        shadow_fill   = 0;
    end

    task automatic report_fault(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        fail_count = fail_count + 1;
    endtask

    // Apply one insert or delete to the shadow queue and form its result
    task automatic apply_queue_op(input logic op, input logic signed [VALUE_W-1:0] val,
                                  output queue_result_t res);
        int pos;
        int hit;
        logic [STATUS_W-1:0] st;
        pos = shadow_fill;
        hit = -1;
        if (op == OP_INSERT)
        begin
            if (shadow_fill >= DEPTH)
                st = ST_OVERFLOW;
            else
            begin
                // place before the first entry not greater than the value
                for (int k = shadow_fill - 1; k >= 0; k--)
                    if (val >= shadow_slots[k])
                        pos = k;
                for (int k = shadow_fill; k > pos; k--)
                    shadow_slots[k] = shadow_slots[k-1];
                shadow_slots[pos] = val;
                shadow_fill = shadow_fill + 1;
                st = ST_DONE;
            end
        end
        else if (shadow_fill == 0)
            st = ST_EMPTY;
        else
        begin
            for (int k = shadow_fill - 1; k >= 0; k--)
                if (shadow_slots[k] == val)
                    hit = k;
            if (hit < 0)
                st = ST_NOTFOUND;
            else
            begin
                // close the gap left by the removed entry
                for (int k = hit; k + 1 < shadow_fill; k++)
                    shadow_slots[k] = shadow_slots[k+1];
                shadow_fill = shadow_fill - 1;
                st = ST_DONE;
            end
        end
        res.status = st;
        res.count  = shadow_fill[COUNT_W-1:0];
        res.head   = (shadow_fill > 0) ? shadow_slots[0] : '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_fill = 0;
            expected_results.delete();
            outstanding = 0;
        end
        else
        begin
            // Check the result word first: it always belongs to an earlier input word
            if (m_tvalid && m_tready)
            begin
                observed.status = m_tdata[STATUS_W-1:0];
                observed.count  = m_tdata[STATUS_W +: COUNT_W];
                observed.head   = m_tdata[STATUS_W+COUNT_W +: VALUE_W];
                results_seen    = results_seen + 1;
                if (expected_results.size() == 0)
                    report_fault($sformatf("result word %0d arrived with nothing pending",
                                           results_seen));
                else
                begin
                    oldest = expected_results.pop_front();
                    if (observed.status != oldest.status)
                        report_fault($sformatf("result %0d status got %0d want %0d",
                                               results_seen, observed.status, oldest.status));
                    if (observed.count != oldest.count)
                        report_fault($sformatf("result %0d count got %0d want %0d",
                                               results_seen, observed.count, oldest.count));
                    if (observed.head != oldest.head)
                        report_fault($sformatf("result %0d head got %0d want %0d",
                                               results_seen, observed.head, oldest.head));
                end
            end
            // Predict the result of an accepted input word
            if (s_tvalid && s_tready)
            begin
                apply_queue_op(s_tuser, s_tdata, predicted);
                expected_results.push_back(predicted);
                if (predicted.status == ST_OVERFLOW)
                    overflow_seen = overflow_seen + 1;
                if (predicted.status == ST_EMPTY)
                    empty_seen = empty_seen + 1;
                if (predicted.status == ST_NOTFOUND)
                    notfound_seen = notfound_seen + 1;
                if (shadow_fill > peak_fill)
                    peak_fill = shadow_fill;
            end
            outstanding = expected_results.size();
        end
    end

endmodule

### tb/sv/sorted_array_priority_queue_test.sv
// Top of the priority queue testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module sorted_array_priority_queue_test;
    import sapq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 525;
    localparam int SEGMENT_LEN  = 25;
    localparam int STEADY_TAIL  = 60;
    localparam int LONG_HOLD    = 80;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata  = '0;
    logic               s_tuser  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [RES_W-1:0]   m_tdata;

    int fail_count;
    int outstanding;
    int results_seen;
    int overflow_seen;
    int empty_seen;
    int notfound_seen;
    int peak_fill;

    // Shared controls of the two drivers
    bit steady        = 1'b0;
    bit hold_request  = 1'b0;
    int long_holds    = 0;

    logic [VALUE_W-1:0] value_pool [6];

    always #10 clk = ~clk;

    sorted_array_priority_queue #(.DEPTH(DEPTH)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sapq_checker #(.DEPTH(DEPTH)) checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .fail_count    (fail_count),
        .outstanding   (outstanding),
        .results_seen  (results_seen),
        .overflow_seen (overflow_seen),
        .empty_seen    (empty_seen),
        .notfound_seen (notfound_seen),
        .peak_fill     (peak_fill)
    );

    // Offer one word, with an optional gap ahead of it, and hold it until taken
    task automatic push_word(input logic op, input logic [VALUE_W-1:0] val);
        int gap;
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= val;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    // Stop offering until every pending result has come back
    task automatic drain_results();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
    endtask

    // Pick a value: mostly from a small pool so that deletes find matches
    function automatic logic [VALUE_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7)
            return value_pool[$urandom_range(0, 5)];
        return $urandom();
    endfunction

    task automatic refresh_pool();
        for (int k = 0; k < 6; k++)
            case ($urandom_range(0, 5))
                0:       value_pool[k] = 32'h7FFF_FFFF;
                1:       value_pool[k] = 32'h8000_0000;
                2:       value_pool[k] = $urandom_range(0, 15);
                default: value_pool[k] = $urandom();
            endcase
    endtask

    // Receiver: random stalls, one long hold-off on request, none in the tail
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                long_holds   = long_holds + 1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD - 1) @(negedge clk);
            end
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                stall = $urandom_range(1, 12);
                m_tready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Stimulus
    initial
    begin
        int sent;
        int segment;
        int insert_pct;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: empty delete, extremes, duplicates, misses, full queue
        push_word(OP_DELETE, 32'd7);
        push_word(OP_INSERT, 32'h7FFF_FFFF);
        push_word(OP_INSERT, 32'h8000_0000);
        push_word(OP_INSERT, 32'h0000_0000);
        push_word(OP_INSERT, 32'hFFFF_FFFF);
        push_word(OP_INSERT, 32'h0000_0000);
        push_word(OP_DELETE, 32'd12345);
        push_word(OP_DELETE, 32'h0000_0000);
        push_word(OP_DELETE, 32'h8000_0000);
        for (int k = 0; k < 13; k++)
            push_word(OP_INSERT, $urandom_range(1, 1000));
        push_word(OP_INSERT, 32'h7FFF_FFFF);
        push_word(OP_DELETE, 32'h7FFF_FFFF);
        drain_results();

        // Random: segments with their own insert bias and value pool
        sent    = 0;
        segment = 0;
        while (sent < RANDOM_ITEMS)
        begin
            refresh_pool();
            case ($urandom_range(0, 2))
                0:       insert_pct = 20;
                1:       insert_pct = 50;
                default: insert_pct = 85;
            endcase
            if (segment == 3 || segment == 12)
                drain_results();
            if (segment == 6)
                hold_request = 1'b1;
            for (int k = 0; k < SEGMENT_LEN && sent < RANDOM_ITEMS; k++)
            begin
                if (sent >= RANDOM_ITEMS - STEADY_TAIL)
                    steady = 1'b1;
                push_word(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE,
                          pick_value());
                sent = sent + 1;
            end
            segment = segment + 1;
        end

        // Let the last results come out, then idle before the report
        drain_results();
        repeat (10) @(negedge clk);

        $display("Ran %0d queue operations (%0d long receiver hold-offs), peak fill %0d of %0d.",
                 results_seen, long_holds, peak_fill, DEPTH);
        $display("Refusals seen: %0d full-queue inserts, %0d empty deletes, %0d missed deletes.",
                 overflow_seen, empty_seen, notfound_seen);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("Timeout with %0d results outstanding", outstanding);
        $display("== FAIL ==");
        $finish;
    end

endmodule
